/* hdl/axis_angle_vertex_tumble_top_assert.svh */
// assertion helpers, clocked on aclk, off while aresetn is low
`ifndef AXIS_ANGLE_VERTEX_TUMBLE_TOP_ASSERT_SVH
`define AXIS_ANGLE_VERTEX_TUMBLE_TOP_ASSERT_SVH

`define AAVT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("aavt check failed");

`define AAVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("aavt check failed");

`endif

/* hdl/aavt_pkg.sv */
package aavt_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic signed [17:0] CORDIC_X0 = 18'sd9949;
    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
    localparam logic [14:0] SPREAD_RESET     = 15'd4096;

    localparam logic REG_TIME_NOW     = 1'b0;
    localparam logic REG_SPREAD_SCALE = 1'b1;

    typedef logic signed [16:0] rel_t;
    typedef logic signed [15:0] crd_t;
    typedef logic signed [34:0] crs_t;
    typedef logic signed [37:0] adt_t;

    typedef struct packed {
        rel_t [2:0] rel;
        crd_t [2:0] cen;
        crs_t [2:0] cr;
        adt_t [2:0] ad;
    } geo_t;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [33:0] z;
        logic               neg;
    } cordic_t;

    function automatic logic [31:0] atan_bam(input int i);
        logic [31:0] r;
        case (i)
            0: r = 32'h20000000;  1: r = 32'h12E4051E;  2: r = 32'h09FB385B;
            3: r = 32'h051111D4;  4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;  7: r = 32'h00517C55;  8: r = 32'h0028BE53;
            9: r = 32'h00145F2F; 10: r = 32'h000A2F98; 11: r = 32'h000517CC;
            12: r = 32'h00028BE6; 13: r = 32'h000145F3; 14: r = 32'h0000A2FA;
            15: r = 32'h0000517D; 16: r = 32'h000028BE; 17: r = 32'h0000145F;
            18: r = 32'h00000A30; 19: r = 32'h00000518; 20: r = 32'h0000028C;
            21: r = 32'h00000146; 22: r = 32'h000000A3; 23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

/* hdl/aavt_cordic_cell.sv */
module aavt_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  aavt_pkg::cordic_t in_cs,
    input  aavt_pkg::geo_t    in_geo,
    output logic              out_valid,
    input  logic              out_ready,
    output aavt_pkg::cordic_t out_cs,
    output aavt_pkg::geo_t    out_geo
);

    localparam logic signed [33:0] ATAN = {2'b00, aavt_pkg::atan_bam(STAGE)};

    logic              valid_reg;
    aavt_pkg::cordic_t cs_reg, cs_next;
    aavt_pkg::geo_t    geo_reg;
    logic signed [17:0] dx, dy;

    assign in_ready = !valid_reg || out_ready;
    assign dx = in_cs.y >>> STAGE;
    assign dy = in_cs.x >>> STAGE;

    always_comb begin
        cs_next = in_cs;
        if (!in_cs.z[33]) begin
            cs_next.x = in_cs.x - dx;
            cs_next.y = in_cs.y + dy;
            cs_next.z = in_cs.z - ATAN;
        end else begin
            cs_next.x = in_cs.x + dx;
            cs_next.y = in_cs.y - dy;
            cs_next.z = in_cs.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cs_reg  <= cs_next;
            geo_reg <= in_geo;
        end
    end

    assign out_valid = valid_reg;
    assign out_cs    = cs_reg;
    assign out_geo   = geo_reg;

endmodule

/* hdl/axis_angle_vertex_tumble_top.sv */
// Tumbles one vertex per clock, unless m_ready stalls the output, about its shard's
// axis: angle = spin_rate * time_now reduced to a binary angle, cos/sin from a
// chain of CORDIC_STAGES cells, then Rodrigues rotation of (vertex - centroid) plus
// centroid * spread_scale, rounded and saturated to Q3.12. A new word is taken every
// cycle unless the output stalls. Three front and three back stages wrap the chain.
// Write time_now and spread_scale only while no word is in flight.
module axis_angle_vertex_tumble_top #(
    parameter int CORDIC_STAGES = aavt_pkg::CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_vertex_x,
    input  logic signed [15:0] s_vertex_y,
    input  logic signed [15:0] s_vertex_z,
    input  logic signed [15:0] s_centroid_x,
    input  logic signed [15:0] s_centroid_y,
    input  logic signed [15:0] s_centroid_z,
    input  logic signed [15:0] s_axis_x,
    input  logic signed [15:0] s_axis_y,
    input  logic signed [15:0] s_axis_z,
    input  logic signed [14:0] s_spin_rate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_pos_x,
    output logic signed [15:0] m_pos_y,
    output logic signed [15:0] m_pos_z
);

    logic [31:0] time_now_reg;
    logic [14:0] spread_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_now_reg     <= '0;
            spread_scale_reg <= aavt_pkg::SPREAD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                aavt_pkg::REG_TIME_NOW:     time_now_reg     <= cfg_data;
                aavt_pkg::REG_SPREAD_SCALE: spread_scale_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // ready chain
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, p1_valid_reg, p2_valid_reg, m_valid_reg;
    logic rdy_s0, rdy_s1, rdy_s2, rdy_p1, rdy_p2, rdy_p3;
    logic                cv_w   [0:CORDIC_STAGES];
    logic                crdy_w [0:CORDIC_STAGES];
    aavt_pkg::cordic_t   cs_w   [0:CORDIC_STAGES];
    aavt_pkg::geo_t      cg_w   [0:CORDIC_STAGES];

    assign rdy_p3 = !m_valid_reg || m_ready;
    assign rdy_p2 = !p2_valid_reg || rdy_p3;
    assign rdy_p1 = !p1_valid_reg || rdy_p2;
    assign crdy_w[CORDIC_STAGES] = rdy_p1;
    assign rdy_s2 = !s2_valid_reg || crdy_w[0];
    assign rdy_s1 = !s1_valid_reg || rdy_s2;
    assign rdy_s0 = !s0_valid_reg || rdy_s1;
    assign s_ready = rdy_s0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (rdy_s0) s0_valid_reg <= s_valid;
            if (rdy_s1) s1_valid_reg <= s0_valid_reg;
            if (rdy_s2) s2_valid_reg <= s1_valid_reg;
            if (rdy_p1) p1_valid_reg <= cv_w[CORDIC_STAGES];
            if (rdy_p2) p2_valid_reg <= p1_valid_reg;
            if (rdy_p3) m_valid_reg  <= p2_valid_reg;
        end
    end

    // stage 0: angle product, offsets
    logic signed [47:0] p_reg, p_next;
    aavt_pkg::rel_t [2:0] rel0_reg, rel0_next;
    aavt_pkg::crd_t [2:0] cen0_reg, a0_reg, cen_in, a_in, v_in;
    logic signed [32:0] time_s;

    assign time_s = $signed({1'b0, time_now_reg});
    assign p_next = s_spin_rate * time_s;
    assign v_in   = {s_vertex_z, s_vertex_y, s_vertex_x};
    assign cen_in = {s_centroid_z, s_centroid_y, s_centroid_x};
    assign a_in   = {s_axis_z, s_axis_y, s_axis_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rel0_next[k] = 17'($signed(v_in[k])) - 17'($signed(cen_in[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_s0 && s_valid) begin
            p_reg    <= p_next;
            rel0_reg <= rel0_next;
            cen0_reg <= cen_in;
            a0_reg   <= a_in;
        end
    end

    // stage 1: angle scaling split in two products, dot and cross products
    logic [23:0]        pl;
    logic signed [23:0] ph;
    logic [53:0]        plk;
    logic [29:0]        plk_hi_reg;
    logic [31:0]        phk_reg, phk_next;
    logic signed [34:0] d_reg, d_next;
    aavt_pkg::crs_t [2:0] cr1_reg, cr1_next;
    aavt_pkg::rel_t [2:0] rel1_reg;
    aavt_pkg::crd_t [2:0] cen1_reg, a1_reg;
    logic signed [32:0] pr [0:2][0:2];

    assign pl  = p_reg[23:0];
    assign ph  = p_reg[47:24];
    assign plk = pl * aavt_pkg::INV_TWO_PI;
    assign phk_next = 32'(ph * $signed({1'b0, aavt_pkg::INV_TWO_PI}));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                pr[i][j] = $signed(a0_reg[i]) * $signed(rel0_reg[j]);
            end
        end
        d_next = 35'(pr[0][0]) + 35'(pr[1][1]) + 35'(pr[2][2]);
        cr1_next[0] = 35'(pr[1][2]) - 35'(pr[2][1]);
        cr1_next[1] = 35'(pr[2][0]) - 35'(pr[0][2]);
        cr1_next[2] = 35'(pr[0][1]) - 35'(pr[1][0]);
    end

    always_ff @(posedge aclk) begin
        if (rdy_s1 && s0_valid_reg) begin
            plk_hi_reg <= plk[53:24];
            phk_reg    <= phk_next;
            d_reg      <= d_next;
            cr1_reg    <= cr1_next;
            rel1_reg   <= rel0_reg;
            cen1_reg   <= cen0_reg;
            a1_reg     <= a0_reg;
        end
    end

    // stage 2: binary angle, quadrant fold, a*(a.v)
    logic [31:0]       bam, bamf;
    logic              neg;
    aavt_pkg::cordic_t cs2_reg, cs2_next;
    aavt_pkg::geo_t    geo2_reg, geo2_next;
    logic signed [50:0] adp;

    assign bam  = phk_reg + {2'b00, plk_hi_reg};
    assign neg  = bam[31] ^ bam[30];
    assign bamf = neg ? {~bam[31], bam[30:0]} : bam;

    always_comb begin
        cs2_next.x   = aavt_pkg::CORDIC_X0;
        cs2_next.y   = '0;
        cs2_next.z   = 34'($signed(bamf));
        cs2_next.neg = neg;
        geo2_next.rel = rel1_reg;
        geo2_next.cen = cen1_reg;
        geo2_next.cr  = cr1_reg;
        for (int k = 0; k < 3; k++) begin
            adp = $signed(a1_reg[k]) * d_reg;
            geo2_next.ad[k] = 38'((adp + 51'sd8192) >>> 14);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_s2 && s1_valid_reg) begin
            cs2_reg  <= cs2_next;
            geo2_reg <= geo2_next;
        end
    end

    assign cv_w[0] = s2_valid_reg;
    assign cs_w[0] = cs2_reg;
    assign cg_w[0] = geo2_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        aavt_cordic_cell #(.STAGE(g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv_w[g]),
            .in_ready  (crdy_w[g]),
            .in_cs     (cs_w[g]),
            .in_geo    (cg_w[g]),
            .out_valid (cv_w[g+1]),
            .out_ready (crdy_w[g+1]),
            .out_cs    (cs_w[g+1]),
            .out_geo   (cg_w[g+1])
        );
    end

    // post 1: unfold and clamp cos/sin
    aavt_pkg::cordic_t  cl;
    logic signed [18:0] xc, yc;
    logic signed [15:0] cos_reg, sin_reg, cos_next, sin_next;
    logic signed [16:0] omc_reg;
    aavt_pkg::geo_t     geo3_reg;

    assign cl = cs_w[CORDIC_STAGES];
    assign xc = cl.neg ? -19'(cl.x) : 19'(cl.x);
    assign yc = cl.neg ? -19'(cl.y) : 19'(cl.y);

    always_comb begin
        if (xc > 19'sd16384)       cos_next = aavt_pkg::ONE_Q14;
        else if (xc < -19'sd16384) cos_next = -aavt_pkg::ONE_Q14;
        else                       cos_next = xc[15:0];
        if (yc > 19'sd16384)       sin_next = aavt_pkg::ONE_Q14;
        else if (yc < -19'sd16384) sin_next = -aavt_pkg::ONE_Q14;
        else                       sin_next = yc[15:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy_p1 && cv_w[CORDIC_STAGES]) begin
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
            omc_reg  <= 17'sd16384 - 17'(cos_next);
            geo3_reg <= cg_w[CORDIC_STAGES];
        end
    end

    // post 2: term products
    logic signed [32:0] t1_reg [0:2];
    logic signed [50:0] t2_reg [0:2];
    logic signed [54:0] t3_reg [0:2];
    logic signed [31:0] t4_reg [0:2];
    logic signed [15:0] spread_s;

    assign spread_s = $signed({1'b0, spread_scale_reg});

    always_ff @(posedge aclk) begin
        if (rdy_p2 && p1_valid_reg) begin
            for (int k = 0; k < 3; k++) begin
                t1_reg[k] <= $signed(geo3_reg.rel[k]) * cos_reg;
                t2_reg[k] <= $signed(geo3_reg.cr[k]) * sin_reg;
                t3_reg[k] <= $signed(geo3_reg.ad[k]) * omc_reg;
                t4_reg[k] <= $signed(geo3_reg.cen[k]) * spread_s;
            end
        end
    end

    // post 3: sum, round, saturate
    logic signed [57:0] acc [0:2];
    logic signed [29:0] rnd [0:2];
    logic signed [15:0] pos_next [0:2];
    logic signed [15:0] pos_reg  [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc[k] = (58'(t1_reg[k]) <<< 14) + 58'(t2_reg[k]) + 58'(t3_reg[k])
                   + (58'(t4_reg[k]) <<< 16);
            rnd[k] = 30'((acc[k] + 58'sd134217728) >>> 28);
            if (rnd[k] > 30'sd32767)       pos_next[k] = 16'sh7FFF;
            else if (rnd[k] < -30'sd32768) pos_next[k] = 16'sh8000;
            else                           pos_next[k] = rnd[k][15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_p3 && p2_valid_reg) begin
            for (int k = 0; k < 3; k++) begin
                pos_reg[k] <= pos_next[k];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pos_x = pos_reg[0];
    assign m_pos_y = pos_reg[1];
    assign m_pos_z = pos_reg[2];

`include "axis_angle_vertex_tumble_top_assert.svh"

    `AAVT_ASSERT_NEXT(a_input_lands, s_valid && s_ready, s0_valid_reg)
    `AAVT_ASSERT_SAME(a_cos_range, p1_valid_reg, cos_reg <= 16'sd16384 && cos_reg >= -16'sd16384)
    `AAVT_ASSERT_SAME(a_ready_drop, $fell(s_ready), s0_valid_reg)
    `AAVT_ASSERT_NEXT(a_out_holds, m_valid && !m_ready, m_valid)

endmodule

/* dv/aavt_checker.sv */
`timescale 1ns / 1ps

module aavt_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_vertex_x,
    input  logic signed [15:0] s_vertex_y,
    input  logic signed [15:0] s_vertex_z,
    input  logic signed [15:0] s_centroid_x,
    input  logic signed [15:0] s_centroid_y,
    input  logic signed [15:0] s_centroid_z,
    input  logic signed [15:0] s_axis_x,
    input  logic signed [15:0] s_axis_y,
    input  logic signed [15:0] s_axis_z,
    input  logic signed [14:0] s_spin_rate,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_pos_x,
    input  logic signed [15:0] m_pos_y,
    input  logic signed [15:0] m_pos_z,
    output int                 fail_count,
    output int                 pending
);

    localparam int STAGES = aavt_pkg::CORDIC_STAGES_DEF;

    logic [31:0] cur_time;
    logic [14:0] cur_spread;
    logic [47:0] pos_q[$];

    function automatic longint sat_lim(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [47:0] tumble_pos(
        input logic signed [15:0] vx, vy, vz, cx, cy, cz, ax, ay, az,
        input logic signed [14:0] spin, input logic [31:0] tnow, input logic [14:0] spr);
        longint v[3], cen[3], a[3], rel[3], cr[3];
        longint p, x, y, z, dx, dy, c, s, omc, d, adv, acc;
        logic [63:0] prod;
        logic [31:0] bam;
        logic neg;
        logic [47:0] r;
        v[0] = vx; v[1] = vy; v[2] = vz;
        cen[0] = cx; cen[1] = cy; cen[2] = cz;
        a[0] = ax; a[1] = ay; a[2] = az;
        for (int k = 0; k < 3; k++) rel[k] = v[k] - cen[k];
        p = longint'(spin) * longint'({32'd0, tnow});
        prod = 64'(p) * 64'd683565276;
        bam = prod[55:24];
        neg = (bam[31:30] == 2'd1) || (bam[31:30] == 2'd2);
        if (neg) bam = bam + 32'h80000000;
        z = longint'(signed'(bam));
        x = 9949; y = 0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'({32'd0, aavt_pkg::atan_bam(i)});
            end else begin
                x += dx; y -= dy; z += longint'({32'd0, aavt_pkg::atan_bam(i)});
            end
        end
        if (neg) begin x = -x; y = -y; end
        c = sat_lim(x, -16384, 16384);
        s = sat_lim(y, -16384, 16384);
        omc = 16384 - c;
        d = a[0] * rel[0] + a[1] * rel[1] + a[2] * rel[2];
        cr[0] = a[1] * rel[2] - a[2] * rel[1];
        cr[1] = a[2] * rel[0] - a[0] * rel[2];
        cr[2] = a[0] * rel[1] - a[1] * rel[0];
        for (int k = 0; k < 3; k++) begin
            adv = (a[k] * d + (64'sd1 <<< 13)) >>> 14;
            acc = rel[k] * c * 16384 + cr[k] * s + adv * omc
                + cen[k] * longint'({17'd0, spr}) * 65536;
            acc = sat_lim((acc + (64'sd1 <<< 27)) >>> 28, -32768, 32767);
            r[16*k +: 16] = acc[15:0];
        end
        return r;
    endfunction

    assign pending = pos_q.size();

    always @(posedge aclk) begin
        logic [47:0] e;
        if (!aresetn) begin
            cur_time <= '0;
            cur_spread <= aavt_pkg::SPREAD_RESET;
            fail_count <= 0;
            pos_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == aavt_pkg::REG_TIME_NOW) cur_time <= cfg_data;
                else cur_spread <= cfg_data[14:0];
            end
            if (s_valid && s_ready)
                pos_q.push_back(tumble_pos(s_vertex_x, s_vertex_y, s_vertex_z,
                    s_centroid_x, s_centroid_y, s_centroid_z,
                    s_axis_x, s_axis_y, s_axis_z, s_spin_rate, cur_time, cur_spread));
            if (m_valid && m_ready) begin
                if (pos_q.size() == 0) begin
                    $display("%0t: unexpected word x=%0d y=%0d z=%0d",
                             $time, m_pos_x, m_pos_y, m_pos_z);
                    fail_count <= fail_count + 1;
                end else begin
                    e = pos_q.pop_front();
                    if (e != {m_pos_z, m_pos_y, m_pos_x}) begin
                        $display("%0t: pos mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                 $time, $signed(e[15:0]), $signed(e[31:16]),
                                 $signed(e[47:32]), m_pos_x, m_pos_y, m_pos_z);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* dv/tb_axis_angle_vertex_tumble_top.sv */
`timescale 1ns / 1ps

module tb_axis_angle_vertex_tumble_top;

    localparam int LATENCY = aavt_pkg::CORDIC_STAGES_DEF + 6;
    localparam int WATCHDOG = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = aavt_pkg::REG_TIME_NOW;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_vertex_x = '0, s_vertex_y = '0, s_vertex_z = '0;
    logic signed [15:0] s_centroid_x = '0, s_centroid_y = '0, s_centroid_z = '0;
    logic signed [15:0] s_axis_x = '0, s_axis_y = '0, s_axis_z = '0;
    logic signed [14:0] s_spin_rate = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_pos_x, m_pos_y, m_pos_z;
    int fail_count, pending;
    int idle_cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_mode = 0;

    always #2 aclk = ~aclk;

    axis_angle_vertex_tumble_top u_dut (.*);

    aavt_checker u_chk (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
        if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_pipe();
        while (pending != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    function automatic logic signed [15:0] rand_axis(input bit wide);
        if (wide) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic send_vertex(input logic signed [15:0] vx, vy, vz, cx, cy, cz,
                               input logic signed [15:0] ax, ay, az,
                               input logic signed [14:0] spin);
        if (burst_left == 0) begin
            gap_left = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
        end
        repeat (gap_left) @(negedge aclk);
        gap_left = 0;
        burst_left--;
        s_valid <= 1'b1;
        s_vertex_x <= vx; s_vertex_y <= vy; s_vertex_z <= vz;
        s_centroid_x <= cx; s_centroid_y <= cy; s_centroid_z <= cz;
        s_axis_x <= ax; s_axis_y <= ay; s_axis_z <= az;
        s_spin_rate <= spin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    task automatic random_vertices(input int n);
        bit wide;
        for (int i = 0; i < n; i++) begin
            wide = ($urandom_range(0, 9) == 0);
            send_vertex(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom),
                        rand_axis(wide), rand_axis(wide), rand_axis(wide),
                        wide ? 15'($urandom)
                             : 15'($signed($urandom_range(0, 16384)) - 8192));
        end
        if (burst_left != 0) begin
            burst_left = 0;
            s_valid <= 1'b0;
        end
    endtask

    initial begin
        logic [31:0] times[6];
        logic [14:0] spreads[6];
        times = '{32'd0, 32'hFFFFFFFF, 32'd4096, 32'd0, 32'd0, 32'd0};
        spreads = '{15'd0, 15'h7FFF, 15'd4096, 15'd0, 15'd0, 15'd0};
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_vertex(16'sh7FFF, -16'sh8000, 16'sd0, -16'sh8000, 16'sh7FFF, 16'sd0,
                    16'sd16384, 16'sd0, 16'sd0, 15'sd8192);
        send_vertex(16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                    16'sd0, 16'sd0, 16'sd16384, -15'sd8192);
        if (burst_left != 0) begin
            burst_left = 0;
            s_valid <= 1'b0;
        end
        drain_pipe();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 3) begin
                write_reg(aavt_pkg::REG_TIME_NOW, times[ph]);
                write_reg(aavt_pkg::REG_SPREAD_SCALE, {17'd0, spreads[ph]});
            end else begin
                write_reg(aavt_pkg::REG_TIME_NOW, $urandom);
                write_reg(aavt_pkg::REG_SPREAD_SCALE, $urandom_range(0, 32767));
            end
            send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000,
                        -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sd9459, 15'sh3FFF);
            send_vertex(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                        16'sd9459, 16'sd9459, 16'sd9459, -15'sh4000);
            send_vertex(16'sd1000, -16'sd2000, 16'sd3000, 16'sd0, 16'sd0, 16'sd0,
                        16'sd0, 16'sd16384, 16'sd0, 15'sd3217);
            random_vertices(170);
            drain_pipe();
        end

        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
